// ===== rtl/core/paged_sync_frame_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// Paged sync frame receiver: assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef PAGED_SYNC_FRAME_RECEIVER_DEFINES_SVH
`define PAGED_SYNC_FRAME_RECEIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PSFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PSFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PSFR_ASSERT_NOW(label, ante, cons, msg)
`define PSFR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/psfr_pkg.sv =====
// ----------------------------------------------------------------------------
// psfr_pkg
// Shared constants and types of the paged sync frame receiver.
// ----------------------------------------------------------------------------
package psfr_pkg;

  localparam int PAYLOAD_LEN      = 40;
  localparam int PAGE_STRIDE      = 26;
  localparam int HEADER_LEN       = 14;
  localparam int FLAGS_BYTE_INDEX = 0;

  localparam int BYTE_W = 8;
  localparam int ADDR_W = 7;
  localparam int CNT_W  = 6;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h3E;  // '>'
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h2A;  // '*'
  localparam logic [BYTE_W-1:0] TRAILER     = 8'h3C;  // '<'

  // One result transaction.
  typedef struct packed {
    logic              frame_good;
    logic              frame_end;
    logic [BYTE_W-1:0] store_data;
    logic [ADDR_W-1:0] store_address;
    logic              store_write;
  } result_t;

endpackage

// ===== rtl/core/psfr_deframer.sv =====
// ----------------------------------------------------------------------------
// psfr_deframer
// Frame state (sync hunt, payload count, write pointer, page) and the
// per-byte result logic. State advances on step_i.
// ----------------------------------------------------------------------------
module psfr_deframer
  import psfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output result_t           result_o
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SECOND,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_e;

  localparam logic [CNT_W-1:0]  LAST_IDX  = CNT_W'(PAYLOAD_LEN - 1);
  localparam logic [CNT_W-1:0]  HDR_IDX   = CNT_W'(HEADER_LEN);
  localparam logic [CNT_W-1:0]  FLAGS_IDX = CNT_W'(FLAGS_BYTE_INDEX);
  localparam logic [ADDR_W-1:0] STRIDE1   = ADDR_W'(PAGE_STRIDE);
  localparam logic [ADDR_W-1:0] STRIDE2   = ADDR_W'(2 * PAGE_STRIDE);

  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [ADDR_W-1:0] wptr_q, wptr_d;
  logic [1:0]        page_q, page_d;

  logic [CNT_W-1:0]  idx;
  logic [ADDR_W-1:0] base;

  assign idx = LAST_IDX - left_q;

  // Page jump applies at the first byte after the header.
  always_comb begin
    base = wptr_q;
    if (idx == HDR_IDX) begin
      if (page_q == 2'd1) begin
        base = wptr_q + STRIDE1;
      end else if (page_q == 2'd2) begin
        base = wptr_q + STRIDE2;
      end
    end
  end

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    wptr_d   = wptr_q;
    page_d   = page_q;
    result_o = '0;
    case (phase_q)
      PH_HUNT: begin
        phase_d = (rx_byte_i == SYNC_FIRST) ? PH_SECOND : PH_HUNT;
      end
      PH_SECOND: begin
        if (rx_byte_i == SYNC_SECOND) begin
          phase_d = PH_PAYLOAD;
          wptr_d  = '0;
          left_d  = LAST_IDX;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        if (idx == FLAGS_IDX) begin
          page_d = rx_byte_i[1:0];
        end
        result_o.store_write   = 1'b1;
        result_o.store_address = base;
        result_o.store_data    = rx_byte_i;
        wptr_d                 = base + ADDR_W'(1);
        if (left_q == '0) begin
          phase_d = PH_TRAILER;
        end else begin
          left_d = left_q - CNT_W'(1);
        end
      end
      PH_TRAILER: begin
        result_o.frame_end  = 1'b1;
        result_o.frame_good = (rx_byte_i == TRAILER);
        phase_d             = PH_HUNT;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      left_q  <= '0;
      wptr_q  <= '0;
      page_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      wptr_q  <= wptr_d;
      page_q  <= page_d;
    end
  end

endmodule

// ===== rtl/core/paged_sync_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// paged_sync_frame_receiver
// Sync-byte deframer that writes payload bytes into a paged record store.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis_*): one link byte per transaction in tdata[7:0].
//   Master stream (m_axis_*): exactly one result transaction per input byte,
//   in input order. tdata carries the store write strobe, address and data;
//   tlast marks the trailer position of a frame and tuser says the trailer
//   matched (frame good).
//   The block hunts for '>' '*', writes the 40 payload bytes to the store
//   (page offset applied after the 14 header bytes), then checks the '<'
//   trailer.
//   Path: an accepted byte passes the input register, then its result is
//   registered in the result register and driven on the master stream.
//   Throughput: one byte per cycle unless the master stalls; psfr_deframer
//   updates the frame state in a loop between input and result registers.
//   Reset (rst_ni low, asynchronous): both pipeline registers empty, hunt
//   restarts, write pointer and page number cleared.
//   When the master stalls, the result register holds, the input register
//   fills, and s_axis_tready_o drops; no byte is lost or repeated.
// ----------------------------------------------------------------------------
`include "paged_sync_frame_receiver_defines.svh"

module paged_sync_frame_receiver
  import psfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [0] store_write, [7:1] store_address,
                                        // [15:8] store_data
  output logic        m_axis_tlast_o,   // frame_end
  output logic        m_axis_tuser_o    // frame_good
);

  // input register
  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  // result register
  logic              out_valid_q;
  result_t           out_q;

  result_t           result;
  logic              advance;

  // Move the held byte through the deframer when the result slot is free
  // or is being drained this cycle.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  psfr_deframer u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .rx_byte_i (in_byte_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.store_data, out_q.store_address, out_q.store_write};
  assign m_axis_tlast_o  = out_q.frame_end;
  assign m_axis_tuser_o  = out_q.frame_good;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PSFR_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q, "result lost after advance")
  `PSFR_ASSERT_NOW(a_good_at_end, out_valid_q && out_q.frame_good, out_q.frame_end, "stray good")
  `PSFR_ASSERT_NOW(a_no_wr_at_end, out_valid_q && out_q.frame_end, !out_q.store_write, "write at end")

endmodule
